// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define AHT_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Condition that implies another in the same cycle
`define AHT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that implies another in the next cycle
`define AHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/aht_pkg.sv =====
// Package for the adaptive heater thermostat: register map, widths and reset values
package aht_pkg;

    localparam int TempW     = 16;
    localparam int SetW      = 11;
    localparam int MarginW   = 7;
    localparam int StepW     = 8;
    localparam int DutyW     = 10;
    localparam int AddrW     = 5;
    localparam int ApbW      = 32;
    localparam int InDataW   = 32;
    localparam int OutDataW  = 40;

    localparam int StallWindowDef = 10;

    localparam logic [SetW-1:0]    TargetRst = 11'd375;
    localparam logic [MarginW-1:0] MarginRst = 7'd10;
    localparam logic               AutoRst   = 1'b0;
    localparam logic [StepW-1:0]   ShortRst  = 8'd10;
    localparam logic [StepW-1:0]   PwmStepRst = 8'd10;
    localparam logic [DutyW-1:0]   PwmStartRst = 10'd512;
    localparam logic [DutyW-1:0]   DutyMax   = 10'd1023;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_TARGET_TEMP   = 3'd0,
        REG_RUNOUT_MARGIN = 3'd1,
        REG_AUTO_ADJUST   = 3'd2,
        REG_SHORT_LIMIT   = 3'd3,
        REG_PWM_STEP      = 3'd4,
        REG_PWM_START     = 3'd5
    } t_reg_idx;

    // One result item
    typedef struct packed {
        logic             temp_drop_alert;
        logic [SetW-1:0]  setpoint;
        logic [TempW-1:0] average_temp;
        logic [DutyW-1:0] pwm_level;
        logic             heater_on;
    } t_result;

endpackage

// ===== rtl/adaptive_heater_thermostat.sv =====
// Adaptive heater thermostat: sample averaging, stepped setpoint and PWM trimming
//
// One sample pair is taken per clock. A transfer on s_axis is held in an input
// register. In the following cycle one pass of logic evaluates the averaging,
// setpoint refresh, stall count, drop check and overshoot tracking. That pass
// updates the state and loads the result register once the result slot is free.
// A result is then offered on m_axis from that register, and items follow each
// other at one per cycle. Throughput falls only while m_axis is stalled with both
// stages full. The PWM level changes by itself only with auto_adjust set; a write
// of pwm_start loads it unless a sample advances in the same cycle. Configuration
// writes belong to idle periods with no sample in flight.
`include "assert_macros.svh"

module adaptive_heater_thermostat
    import aht_pkg::*;
#(
    parameter int STALL_WINDOW = StallWindowDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Sample input
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // [15:0] first_temp, [31:16] second_temp
    // Result output
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // [0] heater_on, [10:1] pwm_level,
                                                // [26:11] average_temp, [37:27] setpoint,
                                                // [38] temp_drop_alert, [39] zero
    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrW-1:0]    paddr,
    input  logic [ApbW-1:0]     pwdata,
    output logic [ApbW-1:0]     prdata,
    output logic                pready
);

    localparam int CntW = $clog2(STALL_WINDOW + 1);

    // Configuration registers
    logic [SetW-1:0]    r_target;
    logic [MarginW-1:0] r_margin;
    logic               r_auto;
    logic [StepW-1:0]   r_short;
    logic [StepW-1:0]   r_pwm_step;
    logic [DutyW-1:0]   r_pwm_start;

    // Control state
    logic [SetW-1:0]    r_setpoint,  n_setpoint;
    logic               r_sp_valid,  n_sp_valid;
    logic [StepW-1:0]   r_down_step, n_down_step;
    logic               r_runout,    n_runout;
    logic [TempW-1:0]   r_peak,      n_peak;
    logic [CntW-1:0]    r_count,     n_count;
    logic [TempW-1:0]   r_stall_ref, n_stall_ref;
    logic [DutyW-1:0]   r_duty,      n_duty;

    // Pipeline registers
    logic               r_in_valid;
    logic [TempW-1:0]   r_first;
    logic [TempW-1:0]   r_second;
    logic               r_out_valid;
    t_result            r_out, n_out;

    logic               w_wr;
    logic               w_pwm_wr;
    logic [2:0]         w_idx;
    logic               w_advance;

    // Combinational working values
    logic [TempW:0]     w_sum;
    logic [TempW-1:0]   w_avg;
    logic               w_heating;
    logic [TempW:0]     w_step_sum;
    logic [CntW-1:0]    w_count_inc;
    logic [TempW+1:0]   w_drop_lhs;
    logic [DutyW:0]     w_duty_up;
    logic [SetW:0]      w_sp_margin;
    logic               w_alert;

    assign pready = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_idx    = paddr[AddrW-1:2];
    assign w_pwm_wr = w_wr && (w_idx == REG_PWM_START);

    // Hold the input stage until the result slot is free
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    // Read back the configuration registers
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_TARGET_TEMP:   prdata = {{(ApbW-SetW){1'b0}}, r_target};
            REG_RUNOUT_MARGIN: prdata = {{(ApbW-MarginW){1'b0}}, r_margin};
            REG_AUTO_ADJUST:   prdata = {{(ApbW-1){1'b0}}, r_auto};
            REG_SHORT_LIMIT:   prdata = {{(ApbW-StepW){1'b0}}, r_short};
            REG_PWM_STEP:      prdata = {{(ApbW-StepW){1'b0}}, r_pwm_step};
            REG_PWM_START:     prdata = {{(ApbW-DutyW){1'b0}}, r_pwm_start};
            default:           prdata = '0;
        endcase
    end

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= TargetRst;
            r_margin    <= MarginRst;
            r_auto      <= AutoRst;
            r_short     <= ShortRst;
            r_pwm_step  <= PwmStepRst;
            r_pwm_start <= PwmStartRst;
        end else if (w_wr) begin
            case (w_idx)
                REG_TARGET_TEMP:   r_target    <= pwdata[SetW-1:0];
                REG_RUNOUT_MARGIN: r_margin    <= pwdata[MarginW-1:0];
                REG_AUTO_ADJUST:   r_auto      <= pwdata[0];
                REG_SHORT_LIMIT:   r_short     <= pwdata[StepW-1:0];
                REG_PWM_STEP:      r_pwm_step  <= pwdata[StepW-1:0];
                REG_PWM_START:     r_pwm_start <= pwdata[DutyW-1:0];
                default: ;
            endcase
        end
    end

    // Evaluate one sample pair against the held state
    always_comb begin
        w_sum       = {1'b0, r_first} + {1'b0, r_second};
        w_avg       = w_sum[TempW:1];
        w_heating   = (w_avg <= {{(TempW-SetW){1'b0}}, r_setpoint});
        w_step_sum  = {1'b0, w_avg} + {{(TempW+1-StepW){1'b0}}, r_short};
        w_alert     = 1'b0;
        w_count_inc = r_count + 1'b1;

        n_setpoint  = r_setpoint;
        n_sp_valid  = r_sp_valid;
        n_down_step = r_down_step;
        n_runout    = r_runout;
        n_peak      = r_peak;
        n_count     = r_count;
        n_stall_ref = r_stall_ref;
        n_duty      = r_duty;

        // Refresh an invalid setpoint: step towards the target or land on it
        if (!r_sp_valid) begin
            if (w_step_sum <= {{(TempW+1-SetW){1'b0}}, r_target}) begin
                n_setpoint  = w_step_sum[SetW-1:0];
                n_down_step = r_pwm_step;
            end else begin
                n_setpoint  = r_target;
                n_down_step = StepW'(1);
            end
            n_sp_valid = 1'b1;
        end

        w_drop_lhs  = {2'b00, w_avg} + {{(TempW+1-StepW){1'b0}}, r_short, 1'b0};
        w_sp_margin = {1'b0, n_setpoint} + {{(SetW+1-MarginW){1'b0}}, r_margin};

        if (w_heating) begin
            n_runout = 1'b0;
            n_peak   = {{(TempW-SetW){1'b0}}, n_setpoint};
            if (r_count == '0) begin
                n_stall_ref = w_avg;
            end
            n_count = w_count_inc;
            // Nudge the duty when the temperature has not moved over a window
            if (w_count_inc >= CntW'(STALL_WINDOW)) begin
                n_count = '0;
                if ((n_stall_ref == w_avg) && (n_setpoint != r_target) &&
                    (r_duty != DutyMax) && r_auto) begin
                    n_duty = r_duty + 1'b1;
                end
            end
            // Large drop: raise the duty, invalidate the setpoint and flag it
            if (w_drop_lhs < {{(TempW+2-SetW){1'b0}}, n_setpoint}) begin
                w_duty_up = {1'b0, n_duty} + {{(DutyW+1-StepW){1'b0}}, r_pwm_step};
                if (!w_duty_up[DutyW] && r_auto) begin
                    n_duty = w_duty_up[DutyW-1:0];
                end
                n_sp_valid = 1'b0;
                w_alert    = 1'b1;
            end else begin
                w_duty_up = '0;
            end
        end else begin
            w_duty_up = '0;
            // Track the overshoot peak, cut the duty once on the way down
            if (w_avg >= r_peak) begin
                n_peak = w_avg;
            end else if (!r_runout) begin
                n_runout   = 1'b1;
                n_sp_valid = 1'b0;
                if ((r_peak > {{(TempW-SetW-1){1'b0}}, w_sp_margin}) &&
                    (r_duty > {{(DutyW-StepW){1'b0}}, n_down_step}) && r_auto) begin
                    n_duty = r_duty - {{(DutyW-StepW){1'b0}}, n_down_step};
                end
            end
        end

        n_out.heater_on       = w_heating;
        n_out.pwm_level       = n_duty;
        n_out.average_temp    = w_avg;
        n_out.setpoint        = n_setpoint;
        n_out.temp_drop_alert = w_alert;
    end

    // Advance the state and the two register stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint  <= '0;
            r_sp_valid  <= 1'b0;
            r_down_step <= '0;
            r_runout    <= 1'b0;
            r_peak      <= '0;
            r_count     <= '0;
            r_duty      <= PwmStartRst;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance) begin
                r_setpoint  <= n_setpoint;
                r_sp_valid  <= n_sp_valid;
                r_down_step <= n_down_step;
                r_runout    <= n_runout;
                r_peak      <= n_peak;
                r_count     <= n_count;
                r_duty      <= n_duty;
            end else if (w_pwm_wr) begin
                r_duty <= pwdata[DutyW-1:0];
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers without reset
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_first  <= s_axis_tdata[TempW-1:0];
            r_second <= s_axis_tdata[2*TempW-1:TempW];
        end
        if (w_advance) begin
            r_stall_ref <= n_stall_ref;
            r_out       <= n_out;
        end
    end

    // Checks
    `AHT_ASSERT_ALWAYS(a_count_range, r_count < CntW'(STALL_WINDOW),
        "stall sample count left its window")
    `AHT_ASSERT_IMPL(a_alert_heating, r_out_valid && r_out.temp_drop_alert,
        r_out.heater_on, "drop alert raised while not heating")
    `AHT_ASSERT_NEXT(a_duty_manual, !r_auto && !w_pwm_wr, r_duty == $past(r_duty),
        "PWM level moved with automatic adjustment off")

endmodule
